[design/vl2n_pkg.sv]
package vl2n_pkg;

  // default vector length limit
  localparam int DEF_MAX_DIM = 16;

  // fixed field widths
  localparam int ELEM_W     = 16;
  localparam int IDX_W      = 4;
  localparam int NORM_OUT_W = 18;
  localparam int Q_W        = 16;

  // magnitude of a component squared, at most 2^30
  localparam int SQ_W = 31;

  // largest quotient magnitudes for each sign
  localparam logic [Q_W-1:0] Q_POS_MAX = 16'h7fff;
  localparam logic [Q_W-1:0] Q_NEG_MAX = 16'h8000;

  // request to the divider
  typedef struct packed {
    logic              start;
    logic              neg;
    logic [ELEM_W-1:0] mag;
  } div_req_t;

  // answer from the divider
  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] value;
  } div_rsp_t;

endpackage

[design/vl2n_elem_if.sv]
interface vl2n_elem_if
  import vl2n_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] element_value;
  logic              last_element;

  modport source (output valid, output element_value, output last_element, input ready);
  modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

[design/vl2n_res_if.sv]
interface vl2n_res_if
  import vl2n_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [Q_W-1:0]        normalized_value;
  logic [IDX_W-1:0]      element_index;
  logic [NORM_OUT_W-1:0] norm_value;
  logic                  last_result;

  modport source (output valid, output normalized_value, output element_index,
                  output norm_value, output last_result, input ready);
  modport sink   (input valid, input normalized_value, input element_index,
                  input norm_value, input last_result, output ready);
endinterface

[design/vector_l2_normalize_top.sv]
// Loading: one word per cycle, back to back; a square is folded into the sum
// the cycle after its word. After the last word: a fold state, then the bit-serial
// square root, one root bit per step, NORM_W bits (18 at MAX_DIM = 16).
// Each result then passes through a memory read, divider start, the divider steps
// (one per quotient bit) and a hand-off, plus any sink stall.
// Reset (rst, synchronous) clears the sum, count and control; store undefined.
module vector_l2_normalize_top
  import vl2n_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic       clk,
  input  logic       rst,
  vl2n_elem_if.sink  elem,
  vl2n_res_if.source res
);

  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int SUM_W  = SQ_W + $clog2(MAX_DIM);
  localparam int NORM_W = (SUM_W + 1) / 2;
  localparam int SRC_W  = 2 * NORM_W;
  localparam int RCNT_W = $clog2(NORM_W);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_FOLD  = 3'd1;
  localparam logic [2:0] S_ROOT  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_START = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;
  localparam logic [2:0] S_SEND  = 3'd6;

  logic [2:0]        state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  k;
  logic [SUM_W-1:0]  sum;
  logic [SQ_W-1:0]   sq;
  logic              sq_pend;
  logic [SRC_W-1:0]  src;
  logic [NORM_W:0]   rrem;
  logic [NORM_W-1:0] root;
  logic [RCNT_W-1:0] rstep;

  logic [ELEM_W-1:0] store [MAX_DIM];
  logic [ELEM_W-1:0] rd_data;

  logic              accept;
  logic              keep;
  logic signed [31:0] prod;
  logic [SUM_W-1:0]  sum_full;
  logic [NORM_W+2:0] rrem2;
  logic [NORM_W+2:0] rtrial;
  logic              rtake;
  logic              k_last;

  div_req_t          dreq;
  div_rsp_t          drsp;

  assign elem.ready = (state == S_LOAD);
  assign accept     = elem.valid && elem.ready;
  assign keep       = count < CNT_W'(MAX_DIM);
  assign prod       = $signed(elem.element_value) * $signed(elem.element_value);
  assign sum_full   = sq_pend ? sum + SUM_W'(sq) : sum;
  assign k_last     = (k == count - 1'b1);

  // root step: bring down two bits, try 4*root + 1
  assign rrem2  = {rrem, src[SRC_W-1 -: 2]};
  assign rtrial = {2'b00, root, 1'b0} << 1 | (NORM_W+3)'(1);
  assign rtake  = rrem2 >= rtrial;

  // element store, registered read
  always_ff @(posedge clk) begin
    if (accept && keep) begin
      store[ADDR_W'(count)] <= elem.element_value;
    end
    rd_data <= store[ADDR_W'(k)];
  end

  // divider request
  always_comb begin
    dreq.start = (state == S_START);
    dreq.neg   = rd_data[ELEM_W-1];
    dreq.mag   = rd_data[ELEM_W-1] ? ELEM_W'(~rd_data + 1'b1) : rd_data;
  end

  vl2n_divider #(
    .NORM_W (NORM_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .norm (root),
    .rsp  (drsp)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      sum       <= '0;
      sq_pend   <= 1'b0;
      k         <= '0;
      res.valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          sum     <= sum_full;
          sq_pend <= accept && keep;
          if (accept && keep) begin
            count <= count + 1'b1;
          end
          if (accept && elem.last_element) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          sum     <= '0;
          sq_pend <= 1'b0;
          k       <= '0;
          state   <= S_ROOT;
        end
        S_ROOT: begin
          if (rstep == RCNT_W'(NORM_W - 1)) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_START;
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (drsp.done) begin
            res.valid <= 1'b1;
            state     <= S_SEND;
          end
        end
        S_SEND: begin
          if (res.ready) begin
            res.valid <= 1'b0;
            if (k_last) begin
              count <= '0;
              state <= S_LOAD;
            end else begin
              k     <= k + 1'b1;
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      sq <= prod[SQ_W-1:0];
    end
    if (state == S_FOLD) begin
      src   <= SRC_W'(sum_full);
      rrem  <= '0;
      root  <= '0;
      rstep <= '0;
    end else if (state == S_ROOT) begin
      src   <= {src[SRC_W-3:0], 2'b00};
      rstep <= rstep + 1'b1;
      rrem  <= rtake ? (NORM_W+1)'(rrem2 - rtrial) : rrem2[NORM_W:0];
      root  <= {root[NORM_W-2:0], rtake};
    end
    if (state == S_WAIT && drsp.done) begin
      res.normalized_value <= drsp.value;
      res.element_index    <= IDX_W'(k);
      res.norm_value       <= NORM_OUT_W'(root);
      res.last_result      <= k_last;
    end
  end

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(elem.ready && res.valid))
    else $error("input taken while a result is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_DIM))
    else $error("element count past limit");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    accept && elem.last_element |=> !elem.ready)
    else $error("input still open after last word");

  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ready && res.last_result |=> elem.ready && count == '0)
    else $error("not back to loading after final result");

endmodule

[design/vl2n_divider.sv]
// Restoring divider: (mag << 15) / norm, one quotient bit a cycle, then
// Q1.15 saturation and sign.
module vl2n_divider
  import vl2n_pkg::*;
#(
  parameter int NORM_W = 18
) (
  input  logic              clk,
  input  logic              rst,
  input  div_req_t          req,
  input  logic [NORM_W-1:0] norm,
  output div_rsp_t          rsp
);

  localparam int CNT_W = $clog2(Q_W);

  logic              busy;
  logic              neg;
  logic [CNT_W-1:0]  step;
  logic [NORM_W-1:0] rem;
  logic [Q_W-1:0]    dbits;
  logic [Q_W-1:0]    quo;

  logic [NORM_W:0]   trial;
  logic              take;
  logic [NORM_W:0]   diff;
  logic [Q_W-1:0]    quo_next;
  logic [Q_W-1:0]    sat_val;

  // one long-division step
  always_comb begin
    trial    = {rem, dbits[Q_W-1]};
    take     = trial >= {1'b0, norm};
    diff     = trial - {1'b0, norm};
    quo_next = {quo[Q_W-2:0], take};
  end

  // saturate and apply sign
  always_comb begin
    if (neg) begin
      sat_val = (quo_next > Q_NEG_MAX) ? Q_NEG_MAX : quo_next;
      sat_val = Q_W'(~sat_val + 1'b1);
    end else begin
      sat_val = (quo_next > Q_POS_MAX) ? Q_POS_MAX : quo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        if (norm == '0) begin
          // all-zero vector
          rsp.done  <= 1'b1;
          rsp.value <= '0;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (step == CNT_W'(Q_W - 1)) begin
          busy      <= 1'b0;
          rsp.done  <= 1'b1;
          rsp.value <= sat_val;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (req.start) begin
      neg   <= req.neg;
      step  <= '0;
      rem   <= NORM_W'(req.mag[ELEM_W-1:1]);
      dbits <= {req.mag[0], {(Q_W-1){1'b0}}};
      quo   <= '0;
    end else if (busy) begin
      step  <= step + 1'b1;
      rem   <= take ? diff[NORM_W-1:0] : trial[NORM_W-1:0];
      dbits <= {dbits[Q_W-2:0], 1'b0};
      quo   <= quo_next;
    end
  end

endmodule
